// File: rtl/wgm_pkg.sv
// Package: widths, character codes and case folding for the glob matcher.
package wgm_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  typedef logic [7:0]       char_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam char_t CHAR_STAR  = 8'h2A;
  localparam char_t CHAR_QMARK = 8'h3F;
  localparam char_t CHAR_UC_A  = 8'h41;
  localparam char_t CHAR_UC_Z  = 8'h5A;
  localparam char_t CASE_DELTA = 8'h20;

  localparam len_t MAX_LEN_L = len_t'(MAX_LEN);

  function automatic char_t fold_case(input char_t c);
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

endpackage

// File: rtl/wgm_if.sv
// Interfaces: character request channel and match result channel.
interface wgm_in_if;
  logic           valid;
  logic           ready;
  logic           mode;
  wgm_pkg::char_t character;
  logic           has_char;
  logic           last;

  modport source(output valid, output mode, output character, output has_char,
                 output last, input ready);
  modport sink(input valid, input mode, input character, input has_char,
               input last, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic too_long;

  modport source(output valid, output matched, output too_long, input ready);
  modport sink(input valid, input matched, input too_long, output ready);
endinterface

// File: rtl/wgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wildcard_glob_matcher.sv
// Top level: glob pattern matcher with '*' and '?' and a backtracking walk.
//
// Requests on in_ch carry one character each. mode=0 appends to the pattern,
// mode=1 to the subject; last closes the string, has_char=0 marks an empty
// one. A pattern request after a closed pattern starts a new pattern. The
// pattern is kept across subjects.
// A subject request with last=1 starts the walk and yields one request on
// out_ch (matched, too_long). Other requests yield nothing.
// Loading takes a request whenever in_ch.ready is high. After the closing
// subject request the block holds in_ch.ready low through S_RD, one S_EV
// state per walk step (one read of each store per step, at most about
// (pattern_length + 1) * subject_length + pattern_length steps) and S_DONE,
// which writes the result register. Too long strings skip the walk.
// The result waits in an output register while out_ch.ready is low; loading
// continues meanwhile, and a following walk holds its result until the
// register frees.
// Reset (synchronous, rst_n low) clears lengths, flags and the output valid;
// store contents are left as they are.
module wildcard_glob_matcher (
  input logic       clk,
  input logic       rst_n,
  wgm_in_if.sink    in_ch,
  wgm_out_if.source out_ch
);
  import wgm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  len_t       plen_r, plen_nxt;
  len_t       slen_r, slen_nxt;
  logic       povf_r, povf_nxt;
  logic       sovf_r, sovf_nxt;
  logic       pdone_r, pdone_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_matched_r, out_matched_nxt;
  logic       out_tl_r, out_tl_nxt;

  len_t       p_r, p_nxt;
  len_t       s_r, s_nxt;
  len_t       star_p_r, star_p_nxt;
  len_t       star_s_r, star_s_nxt;
  logic       have_star_r, have_star_nxt;
  logic       res_r, res_nxt;
  logic       tl_r, tl_nxt;

  logic       acc;
  len_t       eff_plen;
  logic       eff_povf;
  logic       p_we, s_we;
  idx_t       p_raddr, s_raddr;
  char_t      pc, sc;
  logic       p_in, s_in, is_star, chr_ok;
  logic       sovf_new;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = out_matched_r;
  assign out_ch.too_long = out_tl_r;

  assign eff_plen = pdone_r ? '0 : plen_r;
  assign eff_povf = pdone_r ? 1'b0 : povf_r;
  assign p_we     = acc && !in_ch.mode && in_ch.has_char && (eff_plen < MAX_LEN_L);
  assign s_we     = acc && in_ch.mode && in_ch.has_char && (slen_r < MAX_LEN_L);
  assign sovf_new = sovf_r || (in_ch.has_char && (slen_r >= MAX_LEN_L));

  assign p_in    = p_r < plen_r;
  assign s_in    = s_r < slen_r;
  assign is_star = p_in && (pc == CHAR_STAR);
  assign chr_ok  = p_in && ((pc == CHAR_QMARK) || (fold_case(pc) == fold_case(sc)));

  assign p_raddr = (state_r == S_EV) ? p_nxt[IDX_W-1:0] : p_r[IDX_W-1:0];
  assign s_raddr = (state_r == S_EV) ? s_nxt[IDX_W-1:0] : s_r[IDX_W-1:0];

  wgm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pat_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (eff_plen[IDX_W-1:0]),
    .wdata (in_ch.character),
    .raddr (p_raddr),
    .rdata (pc)
  );

  wgm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_subj_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (slen_r[IDX_W-1:0]),
    .wdata (in_ch.character),
    .raddr (s_raddr),
    .rdata (sc)
  );

  always_comb begin
    state_nxt       = state_r;
    plen_nxt        = plen_r;
    slen_nxt        = slen_r;
    povf_nxt        = povf_r;
    sovf_nxt        = sovf_r;
    pdone_nxt       = pdone_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    out_tl_nxt      = out_tl_r;
    p_nxt           = p_r;
    s_nxt           = s_r;
    star_p_nxt      = star_p_r;
    star_s_nxt      = star_s_r;
    have_star_nxt   = have_star_r;
    res_nxt         = res_r;
    tl_nxt          = tl_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!in_ch.mode) begin
            plen_nxt  = eff_plen;
            povf_nxt  = eff_povf;
            pdone_nxt = in_ch.last;
            if (in_ch.has_char) begin
              if (eff_plen < MAX_LEN_L) begin
                plen_nxt = eff_plen + len_t'(1);
              end else begin
                povf_nxt = 1'b1;
              end
            end
          end else begin
            sovf_nxt = sovf_new;
            if (s_we) begin
              slen_nxt = slen_r + len_t'(1);
            end
            if (in_ch.last) begin
              p_nxt         = '0;
              s_nxt         = '0;
              have_star_nxt = 1'b0;
              res_nxt       = 1'b0;
              tl_nxt        = povf_r || sovf_new;
              state_nxt     = (povf_r || sovf_new) ? S_DONE : S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (s_in) begin
          if (is_star) begin
            have_star_nxt = 1'b1;
            star_p_nxt    = p_r;
            star_s_nxt    = s_r;
            p_nxt         = p_r + len_t'(1);
          end else if (chr_ok) begin
            p_nxt = p_r + len_t'(1);
            s_nxt = s_r + len_t'(1);
          end else if (have_star_r) begin
            star_s_nxt = star_s_r + len_t'(1);
            p_nxt      = star_p_r + len_t'(1);
            s_nxt      = star_s_r + len_t'(1);
          end else begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end
        end else if (is_star) begin
          p_nxt = p_r + len_t'(1);
        end else begin
          res_nxt   = (p_r == plen_r);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = res_r && !tl_r;
          out_tl_nxt      = tl_r;
          slen_nxt        = '0;
          sovf_nxt        = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plen_r      <= '0;
      slen_r      <= '0;
      povf_r      <= 1'b0;
      sovf_r      <= 1'b0;
      pdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      slen_r      <= slen_nxt;
      povf_r      <= povf_nxt;
      sovf_r      <= sovf_nxt;
      pdone_r     <= pdone_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
    out_tl_r      <= out_tl_nxt;
    p_r           <= p_nxt;
    s_r           <= s_nxt;
    star_p_r      <= star_p_nxt;
    star_s_r      <= star_s_nxt;
    have_star_r   <= have_star_nxt;
    res_r         <= res_nxt;
    tl_r          <= tl_nxt;
  end

endmodule

// File: test/wildcard_glob_matcher_tb.sv
// Testbench for wildcard_glob_matcher: random and directed loads checked against a predictor.
module wildcard_glob_matcher_tb;
  import wgm_pkg::*;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_SUBJECT = 1'b1;
  localparam int   RAND_ITEMS   = 1875;
  localparam int   CYCLE_LIMIT  = 40000000;
  localparam int   DRAIN_TAIL   = 100;
  localparam int   PRINT_CAP    = 30;

  typedef struct packed {
    logic matched;
    logic too_long;
  } verdict_t;

  class glob_verdict_board;
    char_t       pat_chars[MAX_LEN];
    char_t       subj_chars[MAX_LEN];
    int unsigned pat_len;
    int unsigned subj_len;
    bit          pat_ovf;
    bit          subj_ovf;
    bit          pat_closed;
    verdict_t    pending[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      pat_len      = 0;
      subj_len     = 0;
      pat_ovf      = 0;
      subj_ovf     = 0;
      pat_closed   = 0;
      errors       = 0;
      results_seen = 0;
      foreach (pat_chars[i]) begin
        pat_chars[i]  = '0;
        subj_chars[i] = '0;
      end
    endfunction

    function char_t lower_ascii(char_t c);
      if (c >= 8'h41 && c <= 8'h5A) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    // greedy walk, backtracking to the most recent star
    function bit glob_walk();
      int unsigned s = 0;
      int unsigned p = 0;
      int unsigned star_p = 0;
      int unsigned star_s = 0;
      bit have_star = 0;
      while (s < subj_len) begin
        if (p < pat_len && pat_chars[p] == CHAR_STAR) begin
          have_star = 1;
          star_p = p;
          star_s = s;
          p++;
        end else if (p < pat_len && (pat_chars[p] == CHAR_QMARK ||
                     lower_ascii(pat_chars[p]) == lower_ascii(subj_chars[s]))) begin
          p++;
          s++;
        end else if (have_star) begin
          star_s++;
          p = star_p + 1;
          s = star_s;
        end else begin
          return 0;
        end
      end
      while (p < pat_len && pat_chars[p] == CHAR_STAR) begin
        p++;
      end
      return p == pat_len;
    endfunction

    function void note_request(logic mode, char_t ch, logic has_char, logic last);
      verdict_t v;
      if (mode == MODE_PATTERN) begin
        if (pat_closed) begin
          pat_len    = 0;
          pat_ovf    = 0;
          pat_closed = 0;
        end
        if (has_char) begin
          if (pat_len < MAX_LEN) begin
            pat_chars[pat_len] = ch;
            pat_len++;
          end else begin
            pat_ovf = 1;
          end
        end
        if (last) begin
          pat_closed = 1;
        end
      end else begin
        if (has_char) begin
          if (subj_len < MAX_LEN) begin
            subj_chars[subj_len] = ch;
            subj_len++;
          end else begin
            subj_ovf = 1;
          end
        end
        if (last) begin
          v.too_long = pat_ovf || subj_ovf;
          v.matched  = !v.too_long && glob_walk();
          pending = {pending, v};
          subj_len = 0;
          subj_ovf = 0;
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) begin
        $display("MISMATCH: %s", what);
      end
    endtask

    task check_verdict(logic matched, logic too_long);
      verdict_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d with none pending: matched=%b too_long=%b",
                         results_seen, matched, too_long));
        return;
      end
      want = pending.pop_front();
      if (matched !== want.matched) begin
        report($sformatf("result %0d matched=%b, want %b", results_seen, matched,
                         want.matched));
      end
      if (too_long !== want.too_long) begin
        report($sformatf("result %0d too_long=%b, want %b", results_seen, too_long,
                         want.too_long));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  wgm_in_if  in_ch();
  wgm_out_if out_ch();

  wildcard_glob_matcher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  glob_verdict_board board = new();

  int unsigned reqs_taken   = 0;
  int unsigned cycle_count  = 0;
  int          in_idle_odds = 0;
  int          out_idle_odds = 0;
  bit          calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.check_verdict(out_ch.matched, out_ch.too_long);
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) begin
      @(posedge clk);
    end
    forever begin
      if (!calm && out_idle_odds != 0 && $urandom_range(0, out_idle_odds) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_req(input logic mode, input char_t ch, input logic has_char,
                          input logic last);
    if (!calm && in_idle_odds != 0 && $urandom_range(0, in_idle_odds) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.character <= ch;
    in_ch.has_char  <= has_char;
    in_ch.last      <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(mode, ch, has_char, last);
    reqs_taken++;
    if (reqs_taken >= RAND_ITEMS * 9 / 10) begin
      calm = 1;
    end
  endtask

  // a closing empty string goes out as a single has_char=0 marker
  task automatic send_string(input logic mode, input char_t chars[$], input bit closes);
    if (chars.size() == 0) begin
      if (closes) begin
        send_req(mode, char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      return;
    end
    foreach (chars[i]) begin
      if ($urandom_range(0, 24) == 0) begin
        send_req(mode, char_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_req(mode, chars[i], 1'b1, closes && (i == chars.size() - 1));
    end
  endtask

  function automatic char_t pick_char();
    case ($urandom_range(0, 11))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h41;
      3:       return 8'h42;
      4, 5:    return CHAR_STAR;
      6:       return CHAR_QMARK;
      7:       return ($urandom_range(0, 1) == 1) ? 8'h5A : 8'h7A;
      default: return char_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void shape_subject(input char_t pat[$], output char_t subj[$]);
    char_t c;
    subj = {};
    foreach (pat[i]) begin
      c = pat[i];
      if (c == CHAR_STAR) begin
        repeat ($urandom_range(0, 3)) subj = {subj, pick_char()};
      end else if (c == CHAR_QMARK) begin
        subj = {subj, char_t'($urandom_range(0, 255))};
      end else if ($urandom_range(0, 1) == 1 && ((c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A))) begin
        subj = {subj, char_t'(c ^ 8'h20)};
      end else begin
        subj = {subj, c};
      end
    end
    if (subj.size() != 0 && $urandom_range(0, 3) == 0) begin
      subj[$urandom_range(0, subj.size() - 1)] = pick_char();
    end
  endfunction

  task automatic run_group(input bit go_long);
    char_t pat[$];
    char_t head[$];
    char_t tail[$];
    char_t subj[$];
    int    plen;
    int    cut;
    int    slen;
    bit    split;
    in_idle_odds  = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 1) ? 3 : 12);
    out_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 1) ? 2 : 10);
    if (go_long) begin
      plen = $urandom_range(60, 66);
    end else if ($urandom_range(0, 7) == 0) begin
      plen = 0;
    end else begin
      plen = $urandom_range(1, 8);
    end
    repeat (plen) pat = {pat, pick_char()};
    split = ($urandom_range(0, 7) == 0);
    if (split) begin
      cut = $urandom_range(0, plen);
      for (int i = 0; i < plen; i++) begin
        if (i < cut) begin
          head = {head, pat[i]};
        end else begin
          tail = {tail, pat[i]};
        end
      end
      send_string(MODE_PATTERN, head, 1'b0);
      shape_subject(head, subj);
      send_string(MODE_SUBJECT, subj, 1'b1);
      send_string(MODE_PATTERN, tail, 1'b1);
    end else begin
      send_string(MODE_PATTERN, pat, 1'b1);
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) begin
        subj = {};
        repeat ($urandom_range(0, 10)) subj = {subj, pick_char()};
      end else begin
        shape_subject(pat, subj);
      end
      if (go_long) begin
        slen = $urandom_range(60, 66);
        while (subj.size() > slen) begin
          void'(subj.pop_back());
        end
        while (subj.size() < slen) begin
          subj = {subj, pick_char()};
        end
      end
      send_string(MODE_SUBJECT, subj, 1'b1);
    end
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_req(logic'($urandom_range(0, 1)), char_t'($urandom_range(0, 255)),
                 logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic run_directed();
    // empty pattern against empty and one-char subjects
    send_req(MODE_PATTERN, 8'h00, 1'b0, 1'b1);
    send_req(MODE_SUBJECT, 8'hFF, 1'b0, 1'b1);
    send_req(MODE_SUBJECT, 8'h61, 1'b1, 1'b1);
    // star stays a wildcard against a star in the subject
    send_req(MODE_PATTERN, 8'h41, 1'b1, 1'b0);
    send_req(MODE_PATTERN, CHAR_STAR, 1'b1, 1'b0);
    send_req(MODE_PATTERN, CHAR_QMARK, 1'b1, 1'b1);
    send_req(MODE_SUBJECT, 8'h61, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, CHAR_STAR, 1'b1, 1'b1);
    // empty marker mid-string appends nothing
    send_req(MODE_SUBJECT, 8'h5A, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, 8'h00, 1'b0, 1'b0);
    send_req(MODE_SUBJECT, 8'h78, 1'b1, 1'b1);
    // case folding edges: only A-Z fold
    send_req(MODE_PATTERN, 8'h40, 1'b1, 1'b0);
    send_req(MODE_PATTERN, 8'h5A, 1'b1, 1'b0);
    send_req(MODE_PATTERN, 8'h5B, 1'b1, 1'b1);
    send_req(MODE_SUBJECT, 8'h40, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, 8'h7A, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, 8'h5B, 1'b1, 1'b1);
    send_req(MODE_SUBJECT, 8'h60, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, 8'h7A, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, 8'h7B, 1'b1, 1'b1);
    // subject while the pattern is still open
    send_req(MODE_PATTERN, 8'hFF, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, 8'hFF, 1'b1, 1'b1);
    send_req(MODE_PATTERN, 8'h00, 1'b1, 1'b1);
    send_req(MODE_SUBJECT, 8'hFF, 1'b1, 1'b0);
    send_req(MODE_SUBJECT, 8'h00, 1'b1, 1'b1);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_PATTERN;
    in_ch.character <= 8'h00;
    in_ch.has_char  <= 1'b0;
    in_ch.last      <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (reqs_taken < RAND_ITEMS) begin
      run_group($urandom_range(0, 39) == 0);
    end
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_TAIL) @(posedge clk);
    if (board.pending.size() != 0) begin
      board.report($sformatf("%0d results never arrived", board.pending.size()));
    end
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
